@@ sv/pca_pkg.sv @@
// Package for the periodic calendar alarm: field widths, period mode codes,
// register indexes and the structs passed between the alarm modules.
// No dependencies.
package pca_pkg;

  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MINUTE_W  = 6;
  localparam int unsigned SECOND_W  = 6;
  localparam int unsigned WEEKDAY_W = 3;
  localparam int unsigned YEARDAY_W = 9;

  localparam int unsigned MODE_W    = 3;
  localparam int unsigned OFFSET_W  = 25;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = OFFSET_W;

  // Largest elapsed count: 511 days + 31 h 63 min 63 s fits in 26 bits.
  localparam int unsigned ELAPSED_W = 26;

  localparam int unsigned SECS_MIN  = 60;
  localparam int unsigned SECS_HOUR = 3600;
  localparam int unsigned SECS_DAY  = 86400;

  localparam int unsigned FIRST_WINDOW_SECONDS_DEF = 10;

  localparam logic [MODE_W-1:0] MODE_HOURLY  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DAILY   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WEEKLY  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MONTHLY = 3'd3;
  localparam logic [MODE_W-1:0] MODE_YEARLY  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESET   = MODE_DAILY;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SECONDS = 1'd1;

  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [HOUR_W-1:0]    hour;
    logic [MINUTE_W-1:0]  minute;
    logic [SECOND_W-1:0]  second;
    logic [WEEKDAY_W-1:0] weekday;
    logic [YEARDAY_W-1:0] yearday;
  } tick_t;

  // Calendar keys stored at the last firing.
  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [HOUR_W-1:0]    hour;
    logic [WEEKDAY_W-1:0] weekday;
  } keys_t;

  typedef struct packed {
    logic                 have;
    logic [ELAPSED_W-1:0] secs;
  } elapsed_t;

endpackage

@@ sv/periodic_calendar_alarm.sv @@
// periodic_calendar_alarm: one fire beat per calendar tick beat.
// Path: an accepted tick is held in the input register, then its fire result moves to
// the result register; a stall on the result channel holds the tick in the input register.
// Throughput: one tick per cycle while the result channel does not stall; the fire
// decision and the key update close between the input register and the result register.
// Reset (synchronous, rst_n low): pipeline empty, never fired, mode daily, offset 0.
module periodic_calendar_alarm #(
  parameter int unsigned FIRST_WINDOW_SECONDS = pca_pkg::FIRST_WINDOW_SECONDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tick channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pca_pkg::YEAR_W-1:0]         in_now_year,
  input  logic [pca_pkg::MONTH_W-1:0]        in_now_month,
  input  logic [pca_pkg::DAY_W-1:0]          in_now_day,
  input  logic [pca_pkg::HOUR_W-1:0]         in_now_hour,
  input  logic [pca_pkg::MINUTE_W-1:0]       in_now_minute,
  input  logic [pca_pkg::SECOND_W-1:0]       in_now_second,
  input  logic [pca_pkg::WEEKDAY_W-1:0]      in_now_weekday,
  input  logic [pca_pkg::YEARDAY_W-1:0]      in_now_yearday,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_fire,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pca_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pca_pkg::*;

  // Configuration registers.
  logic [MODE_W-1:0]   period_mode_r;
  logic [OFFSET_W-1:0] offset_seconds_r;

  // Input register stage.
  logic  s1_valid_r;
  logic  s1_valid_nxt;
  tick_t tick_r;

  // Result register stage.
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_fire_r;

  logic      in_accept;
  logic      s1_adv;
  logic      fire;
  logic      fired_before;
  keys_t     last;
  keys_t     cur;
  elapsed_t  elapsed;

  // Writes are taken at any time; the user only writes while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_mode_r    <= MODE_RESET;
      offset_seconds_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PERIOD_MODE:    period_mode_r    <= cfg_data[MODE_W-1:0];
        REG_OFFSET_SECONDS: offset_seconds_r <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held tick whenever the result register is free or draining;
  // stall the tick channel only when the held tick cannot move.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on accept / advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      tick_r.year    <= in_now_year;
      tick_r.month   <= in_now_month;
      tick_r.day     <= in_now_day;
      tick_r.hour    <= in_now_hour;
      tick_r.minute  <= in_now_minute;
      tick_r.second  <= in_now_second;
      tick_r.weekday <= in_now_weekday;
      tick_r.yearday <= in_now_yearday;
    end
    if (s1_adv) begin
      out_fire_r <= fire;
    end
  end

  assign cur.year    = tick_r.year;
  assign cur.month   = tick_r.month;
  assign cur.day     = tick_r.day;
  assign cur.hour    = tick_r.hour;
  assign cur.weekday = tick_r.weekday;

  pca_elapsed u_elapsed (
    .tick         (tick_r),
    .period_mode  (period_mode_r),
    .fired_before (fired_before),
    .last         (last),
    .elapsed      (elapsed)
  );

  // History updates on the same edge the tick moves to the result register,
  // so the next held tick already sees it.
  pca_alarm_state #(
    .FIRST_WINDOW_SECONDS (FIRST_WINDOW_SECONDS)
  ) u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (s1_adv),
    .elapsed        (elapsed),
    .offset_seconds (offset_seconds_r),
    .cur            (cur),
    .fire           (fire),
    .fired_before   (fired_before),
    .last           (last)
  );

  assign out_valid = out_valid_r;
  assign out_fire  = out_fire_r;

  // A firing beat leaves the history marked as fired.
  a_fire_sets_history: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && fire |=> fired_before)
    else $error("history not marked after firing");

  // The tick channel stalls only while a tick is held and blocked.
  a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("tick channel stalled without a blocked tick");

  // An unused period mode never produces a fire beat.
  a_bad_mode_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (period_mode_r > MODE_YEARLY) |=> !out_fire_r)
    else $error("fire with unused period mode");

  // Fired history never clears outside reset.
  a_history_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fired_before |=> fired_before)
    else $error("fired history lost");

endmodule

@@ sv/pca_elapsed.sv @@
// Elapsed-seconds unit of the periodic calendar alarm: picks the period key,
// checks it against the stored keys and forms the count. Uses pca_pkg.
module pca_elapsed (
  input  pca_pkg::tick_t                    tick,
  input  logic [pca_pkg::MODE_W-1:0]        period_mode,
  input  logic                              fired_before,
  input  pca_pkg::keys_t                    last,
  output pca_pkg::elapsed_t                 elapsed
);
  import pca_pkg::*;

  logic [ELAPSED_W-1:0] in_hour;
  logic [ELAPSED_W-1:0] in_day;
  logic [ELAPSED_W-1:0] day_base;

  assign in_hour = ELAPSED_W'(tick.minute) * ELAPSED_W'(SECS_MIN) + ELAPSED_W'(tick.second);
  assign in_day  = ELAPSED_W'(tick.hour) * ELAPSED_W'(SECS_HOUR) + in_hour;

  // Day term per mode; fields taken as decoded, no rebasing.
  always_comb begin
    case (period_mode)
      MODE_WEEKLY:  day_base = ELAPSED_W'(tick.weekday) * ELAPSED_W'(SECS_DAY);
      MODE_MONTHLY: day_base = ELAPSED_W'(tick.day) * ELAPSED_W'(SECS_DAY);
      MODE_YEARLY:  day_base = ELAPSED_W'(tick.yearday) * ELAPSED_W'(SECS_DAY);
      default:      day_base = '0;
    endcase
  end

  always_comb begin
    elapsed.secs = day_base + in_day;
    case (period_mode)
      MODE_HOURLY: begin
        elapsed.have = !fired_before || (tick.hour != last.hour);
        elapsed.secs = in_hour;
      end
      MODE_DAILY:   elapsed.have = !fired_before || (tick.day != last.day);
      MODE_WEEKLY:  elapsed.have = !fired_before || (tick.weekday != last.weekday);
      MODE_MONTHLY: elapsed.have = !fired_before || (tick.month != last.month);
      MODE_YEARLY:  elapsed.have = !fired_before || (tick.year != last.year);
      default:      elapsed.have = 1'b0;
    endcase
  end

endmodule

@@ sv/pca_alarm_state.sv @@
// Fire decision and firing history of the periodic calendar alarm.
// Uses pca_pkg; fed by pca_elapsed.
module pca_alarm_state #(
  parameter int unsigned FIRST_WINDOW_SECONDS = pca_pkg::FIRST_WINDOW_SECONDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              advance,
  input  pca_pkg::elapsed_t                 elapsed,
  input  logic [pca_pkg::OFFSET_W-1:0]      offset_seconds,
  input  pca_pkg::keys_t                    cur,
  output logic                              fire,
  output logic                              fired_before,
  output pca_pkg::keys_t                    last
);
  import pca_pkg::*;

  logic                 fired_before_r;
  keys_t                last_r;
  logic [ELAPSED_W-1:0] lo;
  logic [ELAPSED_W-1:0] hi;
  logic                 reached;

  assign lo      = ELAPSED_W'(offset_seconds);
  assign hi      = lo + ELAPSED_W'(FIRST_WINDOW_SECONDS);
  assign reached = elapsed.secs >= lo;

  // Before the first firing only a short window after the offset counts.
  assign fire = elapsed.have && reached && (fired_before_r || (elapsed.secs <= hi));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fired_before_r <= 1'b0;
    end else if (advance && fire) begin
      fired_before_r <= 1'b1;
    end
  end

  // Keys hold no reset: read only once a firing has written them.
  always_ff @(posedge clk) begin
    if (advance && fire) begin
      last_r <= cur;
    end
  end

  assign fired_before = fired_before_r;
  assign last         = last_r;

endmodule
